// ===== rtl/glrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glrg_pkg
// Shared types and constants of the grid ring gather block.
// ----------------------------------------------------------------------------
package glrg_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_LAG  = 8;

   localparam int DATA_W  = 64;
   localparam int COORD_W = 6;
   localparam int SLOT_W  = 6;
   localparam int LAG_W   = 4;
   localparam int SIZE_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   localparam logic [DATA_W-1:0] MISSING_PATTERN = 64'h7FF8_0000_0000_0000;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_GATHER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LAG       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd2;

   localparam logic [LAG_W-1:0]  RST_LAG       = 4'd1;
   localparam logic [SIZE_W-1:0] RST_GRID_ROWS = 7'd64;
   localparam logic [SIZE_W-1:0] RST_GRID_COLS = 7'd64;

   typedef struct packed {
      logic              missing;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } meta_type;

   typedef struct packed {
      logic [DATA_W-1:0] cell_value;
      meta_type          meta;
   } result_type;

endpackage

// ===== rtl/glrg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glrg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module glrg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/grid_lag_ring_gather_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_lag_ring_gather_top
// Grid of 64-bit cells held in one RAM; a gather streams the ring of cells
// at a configured Chebyshev distance around a centre cell.
// ----------------------------------------------------------------------------
// A write transaction gives no result.
// A gather holds off further requests while one RAM read per ring cell is
// issued; a stalled result side pauses the reads. Results pass through the
// read stage and the result buffer, one per cycle while rsp_ready is high.
// Reset clears the sequencer, the result buffer and the configuration
// (lag 1, 64 rows, 64 columns); the cell RAM is not cleared.
module grid_lag_ring_gather_top
   import glrg_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_LAG  = DEF_MAX_LAG
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [DATA_W-1:0]    req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_cell_value,
   output logic                 rsp_missing,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_TOP, ST_SIDE, ST_BOTTOM} state_type;

   // Configuration registers.
   logic [LAG_W-1:0]  lag_ff;
   logic [SIZE_W-1:0] grid_rows_ff;
   logic [SIZE_W-1:0] grid_cols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff       <= RST_LAG;
         grid_rows_ff <= RST_GRID_ROWS;
         grid_cols_ff <= RST_GRID_COLS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAG:       lag_ff       <= csr_wdata[LAG_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[SIZE_W-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[SIZE_W-1:0];
            default:       ;
         endcase
      end
   end

   logic [LAG_W-1:0]  lag_eff;
   logic [SIZE_W-1:0] nrows_eff;
   logic [SIZE_W-1:0] ncols_eff;

   always_comb begin
      if (lag_ff == '0) begin
         lag_eff = LAG_W'(1);
      end else if (int'(lag_ff) > MAX_LAG) begin
         lag_eff = LAG_W'(MAX_LAG);
      end else begin
         lag_eff = lag_ff;
      end
      nrows_eff = (int'(grid_rows_ff) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : grid_rows_ff;
      ncols_eff = (int'(grid_cols_ff) > MAX_COLS) ? SIZE_W'(MAX_COLS) : grid_cols_ff;
   end

   // Sequencer.
   state_type           state_ff;
   logic [COORD_W-1:0]  row_ff;
   logic [COORD_W-1:0]  col_ff;
   logic [LAG_W-1:0]    ring_lag_ff;
   logic signed [4:0]   dr_ff;
   logic signed [4:0]   dc_ff;
   logic [SLOT_W-1:0]   k_ff;

   logic signed [4:0] ls;
   logic signed [7:0] pos_r;
   logic signed [7:0] pos_c;
   logic              cell_in_grid;
   logic              seq_last;
   logic              issue;
   logic              issue_ok;
   logic              req_fire;
   logic              rsp_fire;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign ls           = $signed({1'b0, ring_lag_ff});
   assign pos_r        = $signed({2'b00, row_ff}) + $signed({{3{dr_ff[4]}}, dr_ff});
   assign pos_c        = $signed({2'b00, col_ff}) + $signed({{3{dc_ff[4]}}, dc_ff});
   assign cell_in_grid = !pos_r[7] && !pos_c[7]
                         && (pos_r < $signed({1'b0, nrows_eff}))
                         && (pos_c < $signed({1'b0, ncols_eff}));
   assign seq_last     = (state_ff == ST_BOTTOM) && (dc_ff == ls);
   assign issue        = (state_ff != ST_IDLE) && issue_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_cmd == CMD_GATHER) begin
                  state_ff    <= ST_TOP;
                  row_ff      <= req_row;
                  col_ff      <= req_col;
                  ring_lag_ff <= lag_eff;
                  dr_ff       <= -$signed({1'b0, lag_eff});
                  dc_ff       <= -$signed({1'b0, lag_eff});
                  k_ff        <= '0;
               end
            end
            ST_TOP: begin
               if (issue) begin
                  k_ff <= k_ff + SLOT_W'(1);
                  if (dc_ff == ls) begin
                     state_ff <= ST_SIDE;
                     dr_ff    <= 5'sd1 - ls;
                     dc_ff    <= -ls;
                  end else begin
                     dc_ff <= dc_ff + 5'sd1;
                  end
               end
            end
            ST_SIDE: begin
               if (issue) begin
                  k_ff <= k_ff + SLOT_W'(1);
                  if (dc_ff == -ls) begin
                     dc_ff <= ls;
                  end else if (dr_ff == ls - 5'sd1) begin
                     state_ff <= ST_BOTTOM;
                     dr_ff    <= ls;
                     dc_ff    <= -ls;
                  end else begin
                     dr_ff <= dr_ff + 5'sd1;
                     dc_ff <= -ls;
                  end
               end
            end
            ST_BOTTOM: begin
               if (issue) begin
                  k_ff <= k_ff + SLOT_W'(1);
                  if (seq_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     dc_ff <= dc_ff + 5'sd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Cell RAM.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign wr_en   = req_fire && (req_cmd == CMD_WRITE)
                    && (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
   assign wr_addr = AW'(int'(req_row) * MAX_COLS + int'(req_col));
   assign rd_addr = AW'(int'(pos_r[COORD_W-1:0]) * MAX_COLS + int'(pos_c[COORD_W-1:0]));

   glrg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read stage and two-entry result buffer.
   logic       p1_valid_ff;
   meta_type   p1_meta_ff;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   result_type arrive;
   logic [1:0] occupancy;

   assign occupancy = 2'(out_valid_ff) + 2'(skid_valid_ff) + 2'(p1_valid_ff);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign issue_ok  = (occupancy < 2'd2) || (occupancy == 2'd2 && rsp_fire);

   assign arrive.cell_value = p1_meta_ff.missing ? MISSING_PATTERN : rd_data;
   assign arrive.meta       = p1_meta_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
      if (!out_valid_in && skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (p1_valid_ff) begin
         if (!out_valid_in) begin
            out_in       = arrive;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = arrive;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff   <= issue;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      p1_meta_ff.missing <= !cell_in_grid;
      p1_meta_ff.slot    <= k_ff;
      p1_meta_ff.last    <= seq_last;
      out_ff             <= out_in;
      skid_ff            <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cell_value = out_ff.cell_value;
   assign rsp_missing    = out_ff.meta.missing;
   assign rsp_slot       = out_ff.meta.slot;
   assign rsp_last       = out_ff.meta.last;

   // The buffer never holds more results than it has room for.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(out_valid_ff && skid_valid_ff && p1_valid_ff))
      else $error("result buffer overflow");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a head entry");

   a_missing_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_missing |-> rsp_cell_value == MISSING_PATTERN)
      else $error("missing result without the missing pattern");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_slot[2:0] == 3'b111)
      else $error("final result at a slot that is not a ring end");

   a_gather_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == CMD_GATHER |=> state_ff == ST_TOP)
      else $error("gather transaction did not start the sequencer");

endmodule

// ===== tb/grid_lag_ring_gather_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_lag_ring_gather_top_test
// Self-checking bench for the grid ring gather block. A scoreboard keeps its
// own copy of the cell grid and of the configuration. It predicts the ring
// results of every accepted gather and checks the result stream in order.
// The bench writes every in-grid ring cell before it gathers that ring. It
// steps through several ring distances and grid sizes, including the
// saturated and empty ones. Both channels see random idle gaps.
// ----------------------------------------------------------------------------
module grid_lag_ring_gather_top_test
   import glrg_pkg::*;
();

   localparam int GRID_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEMS_PER_SETTING = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   class ring_scoreboard;
      logic [DATA_W-1:0] cell_mem [GRID_CELLS];
      bit                written [GRID_CELLS];
      logic [LAG_W-1:0]  lag_cfg;
      logic [SIZE_W-1:0] rows_cfg;
      logic [SIZE_W-1:0] cols_cfg;
      result_type        ring_expect_q[$];
      int                mismatches;

      function new();
         lag_cfg = RST_LAG;
         rows_cfg = RST_GRID_ROWS;
         cols_cfg = RST_GRID_COLS;
         mismatches = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_LAG: lag_cfg = data[LAG_W-1:0];
            CSR_GRID_ROWS: rows_cfg = data;
            CSR_GRID_COLS: cols_cfg = data;
            default: ;
         endcase
      endfunction

      function int active_lag();
         if (lag_cfg < 1) return 1;
         if (lag_cfg > DEF_MAX_LAG) return DEF_MAX_LAG;
         return int'(lag_cfg);
      endfunction

      function int active_rows();
         return (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_cfg);
      endfunction

      function int active_cols();
         return (cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_cfg);
      endfunction

      function bit in_grid(int r, int c);
         return r >= 0 && c >= 0 && r < active_rows() && c < active_cols();
      endfunction

      // Position k of the ring: top row, then left/right pairs, then bottom row.
      function void ring_coord(int k, int row, int col, output int r, output int c);
         int lag_n;
         int j;
         lag_n = active_lag();
         if (k < 2 * lag_n + 1) begin
            r = row - lag_n;
            c = col - lag_n + k;
         end else if (k < 6 * lag_n - 1) begin
            j = k - (2 * lag_n + 1);
            r = row - (lag_n - 1) + j / 2;
            c = (j % 2 == 1) ? col + lag_n : col - lag_n;
         end else begin
            j = k - (6 * lag_n - 1);
            r = row + lag_n;
            c = col - lag_n + j;
         end
      endfunction

      function void note_request(logic cmd, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                 logic [DATA_W-1:0] value);
         int total;
         int r;
         int c;
         result_type exp_res;
         if (cmd == CMD_WRITE) begin
            cell_mem[int'(row) * DEF_MAX_COLS + int'(col)] = value;
            written[int'(row) * DEF_MAX_COLS + int'(col)] = 1'b1;
            return;
         end
         total = 8 * active_lag();
         for (int k = 0; k < total; k++) begin
            ring_coord(k, int'(row), int'(col), r, c);
            if (in_grid(r, c)) begin
               exp_res.cell_value = cell_mem[r * DEF_MAX_COLS + c];
               exp_res.meta.missing = 1'b0;
            end else begin
               exp_res.cell_value = MISSING_PATTERN;
               exp_res.meta.missing = 1'b1;
            end
            exp_res.meta.slot = k[SLOT_W-1:0];
            exp_res.meta.last = (k == total - 1);
            ring_expect_q.insert(ring_expect_q.size(), exp_res);
         end
      endfunction

      function void check_result(result_type got);
         result_type exp_res;
         if (ring_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result transaction value=%h missing=%b %s%0d last=%b",
                        $realtime, got.cell_value, got.meta.missing, "slot=",
                        got.meta.slot, got.meta.last);
            return;
         end
         exp_res = ring_expect_q.pop_front();
         if (got.cell_value !== exp_res.cell_value || got.meta.missing !== exp_res.meta.missing ||
             got.meta.slot !== exp_res.meta.slot || got.meta.last !== exp_res.meta.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch exp value=%h missing=%b slot=%0d last=%b, ",
                         "got value=%h missing=%b slot=%0d last=%b"},
                        $realtime, exp_res.cell_value, exp_res.meta.missing,
                        exp_res.meta.slot, exp_res.meta.last, got.cell_value,
                        got.meta.missing, got.meta.slot, got.meta.last);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_WRITE;
   logic [COORD_W-1:0]   req_row = '0;
   logic [COORD_W-1:0]   req_col = '0;
   logic [DATA_W-1:0]    req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DATA_W-1:0]    rsp_cell_value;
   logic                 rsp_missing;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   ring_scoreboard sb = new();
   logic quiet_mode = 1'b0;
   int   rsp_stall_left = 0;
   int   stall_cycles = 0;
   int   sent_count = 0;

   grid_lag_ring_gather_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_row(req_row),
      .req_col(req_col),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_value(rsp_cell_value),
      .rsp_missing(rsp_missing),
      .rsp_slot(rsp_slot),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_len();
      int pick;
      if (quiet_mode) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return MISSING_PATTERN;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   always @(posedge clock) begin
      int gap;
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         gap = idle_len();
         rsp_stall_left <= (gap > 0) ? gap - 1 : 0;
         rsp_ready <= (gap == 0);
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.cell_value = rsp_cell_value;
         got.meta.missing = rsp_missing;
         got.meta.slot = rsp_slot;
         got.meta.last = rsp_last;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(logic cmd, int row, int col, logic [DATA_W-1:0] value);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_row <= row[COORD_W-1:0];
      req_col <= col[COORD_W-1:0];
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, row[COORD_W-1:0], col[COORD_W-1:0], value);
      sent_count++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Every in-grid ring cell gets a value before the gather reads it.
   task automatic gather_at(int row, int col);
      int r;
      int c;
      for (int k = 0; k < 8 * sb.active_lag(); k++) begin
         sb.ring_coord(k, row, col, r, c);
         if (sb.in_grid(r, c) && !sb.written[r * DEF_MAX_COLS + c])
            send_request(CMD_WRITE, r, c, random_value());
      end
      send_request(CMD_GATHER, row, col, random_value());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.ring_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_coord(int size_n);
      int top;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
      top = size_n + sb.active_lag();
      return $urandom_range(0, (top > 63) ? 63 : top);
   endfunction

   initial begin
      logic [CSR_DAT_W-1:0] setting_list [7][3] = '{
         '{7'd0, 7'd127, 7'd100},
         '{7'd8, 7'd1, 7'd1},
         '{7'h7F, 7'd0, 7'd64},
         '{7'd3, 7'd5, 7'd7},
         '{7'd9, 7'd64, 7'd1},
         '{7'd2, 7'd64, 7'd64},
         '{7'd1, 7'd33, 7'd20}
      };
      int budget_end;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(CMD_WRITE, 0, 1, '0);
      send_request(CMD_WRITE, 1, 0, '1);
      send_request(CMD_WRITE, 1, 1, MISSING_PATTERN);
      send_request(CMD_WRITE, 62, 62, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_WRITE, 62, 63, 64'h5555_5555_5555_5555);
      gather_at(0, 0);
      gather_at(63, 63);
      gather_at(0, 63);
      gather_at(63, 0);
      gather_at(30, 41);
      gather_at(1, 1);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         write_csr(CSR_LAG, setting_list[p][0]);
         write_csr(CSR_GRID_ROWS, setting_list[p][1]);
         write_csr(CSR_GRID_COLS, setting_list[p][2]);
         if (p == 0)
            write_csr(CSR_UNUSED, 7'h7F);
         quiet_mode <= (p == 2);
         budget_end = sent_count + ITEMS_PER_SETTING;
         while (sent_count < budget_end) begin
            if ($urandom_range(0, 99) < 40)
               send_request(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                            random_value());
            else
               gather_at(pick_coord(sb.active_rows()), pick_coord(sb.active_cols()));
         end
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.ring_expect_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/glrg_pkg.sv
rtl/glrg_ram.sv
rtl/grid_lag_ring_gather_top.sv
tb/grid_lag_ring_gather_top_test.sv
